FILE: hw/rtl/lcd_pkg.sv
package lcd_pkg;

	// store geometry
	localparam int NUM_BINS  = 1024;
	localparam int NUM_BEAMS = 2;
	localparam int DEPTH     = NUM_BINS * NUM_BEAMS;
	localparam int ADDR_W    = $clog2(DEPTH);

	// field and datapath widths
	localparam int SUM_W   = 48;
	localparam int IDX_W   = 11;
	localparam int SHARE_W = 26;
	localparam int FRAC_W  = 17;

	localparam logic [FRAC_W-1:0] Q16_ONE      = 17'h10000;
	localparam logic [15:0]       INV_DT_RESET = 16'd256;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// command codes
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_DEPOSIT = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic               beam;
		logic [9:0]         bin;
		logic [9:0]         neighbor_bin;
		logic signed [15:0] offset;
		logic signed [23:0] charge;
		logic               active;
	} lcd_req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_here;
		logic signed [SUM_W-1:0] sum_shifted;
		logic                    saturated;
	} lcd_rsp_t;

	typedef struct packed {
		logic [SUM_W-1:0] value;
		logic             sat;
	} lcd_sat_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_WR1,
		S_WR2,
		S_OUT
	} lcd_state_t;

endpackage

FILE: hw/rtl/linear_charge_deposition_core.sv
// Linear charge deposition into two binned current stores per beam.
// Requests arrive on req_valid / req_ready with the fields of lcd_req_t;
// every request gives exactly one response on rsp_valid / rsp_ready.
// cfg_we loads inv_dt from cfg_data into a register; write it only while idle.
// Each store is a single memory of NUM_BEAMS x NUM_BINS 48-bit entries with
// one write port and two registered read ports.
// A deposit runs through three multiply steps and two read-modify-write
// steps (own bin first, then neighbour, forwarded when both are the same
// entry), then the output step; a new request is taken only once the last
// response is registered. A read goes from the first multiply step, which
// reads the stores, straight to the output step. A clear sweeps one entry
// of both stores per cycle over all NUM_BEAMS x NUM_BINS (2048) entries.
// After reset the same clearing pass runs with req_ready low; inv_dt
// returns to 256 and cfg writes are taken during the pass.
// The response sits in an output register: a request is taken while the
// last response still waits, and if the receiver stalls the block holds in
// its final step until the register frees.
module linear_charge_deposition_core
	import lcd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic [15:0] cfg_data,
	input  logic     req_valid,
	output logic     req_ready,
	input  lcd_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output lcd_rsp_t rsp
);

	// store memories
	logic [SUM_W-1:0] mem_direct  [DEPTH];
	logic [SUM_W-1:0] mem_shifted [DEPTH];

	lcd_state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic              clr_reply_q;
	logic              clr_last;
	logic [15:0]       inv_dt_q;
	logic              rsp_valid_q;
	lcd_rsp_t          rsp_q;

	// request fields
	logic [1:0]         cmd_q;
	logic               beam_q;
	logic [9:0]         bin_q;
	logic [9:0]         nbr_q;
	logic [15:0]        mag_q;
	logic signed [23:0] charge_q;
	logic               dep_ok_q;
	logic               rd_ok_q;

	// arithmetic
	logic [FRAC_W-1:0]        f_q, w_q;
	logic [31:0]              f_raw;
	logic [FRAC_W-1:0]        f_clamp;
	logic [32:0]              fi_q, wi_q;
	logic signed [57:0]       prod_share, prod_nshare;
	logic signed [SHARE_W-1:0] share_q, nshare_q;
	logic                     sat_q;

	// memory ports
	logic             re;
	logic             we_d, we_s;
	logic [ADDR_W-1:0] wa_d, wa_s;
	logic [SUM_W-1:0] wd_d, wd_s;
	logic [ADDR_W-1:0] ra_d0, ra_d1, ra_s0, ra_s1;
	logic [SUM_W-1:0] rd_d0_q, rd_d1_q, rd_s0_q, rd_s1_q;
	logic [SUM_W-1:0] wr1_d_q, wr1_s_q;

	// bin indices and range checks
	logic [IDX_W-1:0] idx_bin, idx_bin1, idx_nbr, idx_nbr1;
	logic ok_bin, ok_bin1, ok_nbr, ok_nbr1;
	logic [15:0] mag_w;
	logic        beam_ok_w;

	// read-modify-write adders
	logic [SUM_W-1:0]          old_d, old_s;
	logic signed [SHARE_W-1:0] add_v;
	lcd_sat_t                  sum_d, sum_s;

	function automatic lcd_sat_t sat_add(input logic [SUM_W-1:0] a,
			input logic signed [SHARE_W-1:0] b);
		logic [SUM_W:0] s;
		lcd_sat_t r;
		s = {a[SUM_W-1], a} + {{(SUM_W + 1 - SHARE_W){b[SHARE_W-1]}}, b};
		r.sat = s[SUM_W] ^ s[SUM_W-1];
		if (r.sat) begin
			r.value = s[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			r.value = s[SUM_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] entry_addr(input logic beam,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(ADDR_W'(beam) * ADDR_W'(NUM_BINS) + ADDR_W'(idx));
	endfunction

	assign idx_bin  = {1'b0, bin_q};
	assign idx_nbr  = {1'b0, nbr_q};
	assign idx_bin1 = idx_bin + IDX_W'(1);
	assign idx_nbr1 = idx_nbr + IDX_W'(1);
	assign ok_bin   = 32'(idx_bin) < NUM_BINS;
	assign ok_nbr   = 32'(idx_nbr) < NUM_BINS;
	assign ok_bin1  = 32'(idx_bin1) < NUM_BINS;
	assign ok_nbr1  = 32'(idx_nbr1) < NUM_BINS;
	assign clr_last = clr_q == ADDR_W'(DEPTH - 1);

	assign mag_w     = req.offset[15] ? 16'(-req.offset) : 16'(req.offset);
	assign beam_ok_w = 32'(req.beam) < NUM_BEAMS;

	// read addresses: a read looks at the same bin in both stores
	assign ra_d0 = entry_addr(beam_q, idx_bin);
	assign ra_d1 = entry_addr(beam_q, idx_nbr);
	assign ra_s0 = entry_addr(beam_q, (cmd_q == CMD_READ) ? idx_bin : idx_bin1);
	assign ra_s1 = entry_addr(beam_q, idx_nbr1);

	// fraction, clamped at one
	assign f_raw   = mag_q * inv_dt_q;
	assign f_clamp = (f_raw > 32'(Q16_ONE)) ? Q16_ONE : f_raw[FRAC_W-1:0];

	assign prod_share  = charge_q * $signed({1'b0, wi_q});
	assign prod_nshare = charge_q * $signed({1'b0, fi_q});

	// own bin in the first write step, neighbour in the second
	always_comb begin
		if (state_q == S_WR1) begin
			old_d = rd_d0_q;
			old_s = rd_s0_q;
			add_v = share_q;
		end else begin
			old_d = (nbr_q == bin_q) ? wr1_d_q : rd_d1_q;
			old_s = (nbr_q == bin_q) ? wr1_s_q : rd_s1_q;
			add_v = nshare_q;
		end
		sum_d = sat_add(old_d, add_v);
		sum_s = sat_add(old_s, add_v);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = clr_reply_q ? S_OUT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req.cmd == CMD_CLEAR) ? S_CLEAR : S_MUL1;
				end
			end
			S_MUL1: state_d = (cmd_q == CMD_DEPOSIT) ? S_MUL2 : S_OUT;
			S_MUL2: state_d = S_MUL3;
			S_MUL3: state_d = S_WR1;
			S_WR1:  state_d = S_WR2;
			S_WR2:  state_d = S_OUT;
			S_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs and memory strobes
	always_comb begin
		req_ready = 1'b0;
		re        = 1'b0;
		we_d      = 1'b0;
		we_s      = 1'b0;
		wa_d      = entry_addr(beam_q, idx_bin);
		wa_s      = entry_addr(beam_q, idx_bin1);
		wd_d      = sum_d.value;
		wd_s      = sum_s.value;
		case (state_q)
			S_CLEAR: begin
				we_d = 1'b1;
				we_s = 1'b1;
				wa_d = clr_q;
				wa_s = clr_q;
				wd_d = '0;
				wd_s = '0;
			end
			S_IDLE: req_ready = 1'b1;
			S_MUL1: re = 1'b1;
			S_WR1: begin
				we_d = dep_ok_q && ok_bin;
				we_s = dep_ok_q && ok_bin1;
			end
			S_WR2: begin
				we_d = dep_ok_q && ok_nbr;
				we_s = dep_ok_q && ok_nbr1;
				wa_d = entry_addr(beam_q, idx_nbr);
				wa_s = entry_addr(beam_q, idx_nbr1);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			clr_reply_q <= 1'b0;
			inv_dt_q    <= INV_DT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				inv_dt_q <= cfg_data;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == S_IDLE && req_valid && req.cmd == CMD_CLEAR) begin
				clr_q       <= '0;
				clr_reply_q <= 1'b1;
			end
			if (state_q == S_OUT && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture and arithmetic steps
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			cmd_q    <= req.cmd;
			beam_q   <= req.beam;
			bin_q    <= req.bin;
			nbr_q    <= req.neighbor_bin;
			mag_q    <= mag_w;
			charge_q <= req.charge;
			dep_ok_q <= req.active && beam_ok_w;
			rd_ok_q  <= beam_ok_w && (32'(req.bin) < NUM_BINS);
			sat_q    <= 1'b0;
		end
		if (state_q == S_MUL1) begin
			f_q <= f_clamp;
			w_q <= Q16_ONE - f_clamp;
		end
		if (state_q == S_MUL2) begin
			fi_q <= f_q * inv_dt_q;
			wi_q <= w_q * inv_dt_q;
		end
		if (state_q == S_MUL3) begin
			share_q  <= prod_share[57:32];
			nshare_q <= prod_nshare[57:32];
		end
		if (state_q == S_WR1) begin
			wr1_d_q <= sum_d.value;
			wr1_s_q <= sum_s.value;
		end
		if (state_q == S_WR1 || state_q == S_WR2) begin
			sat_q <= sat_q || (we_d && sum_d.sat) || (we_s && sum_s.sat);
		end
		if (state_q == S_OUT && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.sum_here    <= (cmd_q == CMD_READ && rd_ok_q) ? rd_d0_q : '0;
			rsp_q.sum_shifted <= (cmd_q == CMD_READ && rd_ok_q) ? rd_s0_q : '0;
			rsp_q.saturated   <= (cmd_q == CMD_DEPOSIT) && sat_q;
		end
	end

	// direct store
	always_ff @(posedge clk) begin
		if (we_d) begin
			mem_direct[wa_d] <= wd_d;
		end
		if (re) begin
			rd_d0_q <= mem_direct[ra_d0];
			rd_d1_q <= mem_direct[ra_d1];
		end
	end

	// shifted store
	always_ff @(posedge clk) begin
		if (we_s) begin
			mem_shifted[wa_s] <= wd_s;
		end
		if (re) begin
			rd_s0_q <= mem_shifted[ra_s0];
			rd_s1_q <= mem_shifted[ra_s1];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// a clear request starts a full sweep from the first entry
	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.cmd == CMD_CLEAR) |=>
		(state_q == S_CLEAR && clr_q == '0))
		else $error("clear request did not start a sweep");

	// no store write while waiting for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(we_d || we_s))
		else $error("store written while idle");

	// a saturation flag only comes with a deposit, whose sums are zero
	a_sat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.saturated) |->
		(rsp.sum_here == '0 && rsp.sum_shifted == '0))
		else $error("saturation flag on a read response");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import lcd_pkg::*;

	// the command code that the block leaves unused
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_PRINTED = 40;
	localparam longint SUM_HI = SUM_MAX;
	localparam longint SUM_LO = SUM_MIN;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	lcd_req_t    req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	lcd_rsp_t    rsp;

	// own copy of the current stores and of the bin-width register
	longint      here_store [NUM_BEAMS][NUM_BINS];
	longint      shift_store[NUM_BEAMS][NUM_BINS];
	logic [15:0] inv_dt_now;

	lcd_rsp_t    pending_rsps[$];
	int          send_idle_pct = 0;
	int          rsp_stall_pct = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          rsp_count = 0;
	int          n_deposits = 0;
	int          n_reads = 0;
	int          n_clears = 0;
	int          n_spare = 0;

	linear_charge_deposition_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
			input logic [SUM_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("mismatch in %s: got %h, expected %h (cycle %0d)", what, got, want,
				cycle_count);
	endtask

	// saturating add into one entry, writes past the last bin are dropped
	function automatic bit accumulate(input bit to_shifted, input int beam_no, input int idx,
			input longint amount);
		longint total;
		bit     clipped;
		clipped = 1'b0;
		if (idx >= NUM_BINS)
			return 1'b0;
		total = (to_shifted ? shift_store[beam_no][idx] : here_store[beam_no][idx]) + amount;
		if (total > SUM_HI) begin
			total = SUM_HI;
			clipped = 1'b1;
		end else if (total < SUM_LO) begin
			total = SUM_LO;
			clipped = 1'b1;
		end
		if (to_shifted)
			shift_store[beam_no][idx] = total;
		else
			here_store[beam_no][idx] = total;
		return clipped;
	endfunction

	// expected response of one request, updating the store copies
	function automatic lcd_rsp_t predict_deposition(input lcd_req_t r);
		lcd_rsp_t res;
		longint   off, mag, chg, frac, own_w, inv, share, nshare;
		bit       clip;
		int       b, i;
		res = '0;
		case (r.cmd)
			CMD_CLEAR: begin
				for (b = 0; b < NUM_BEAMS; b++)
					for (i = 0; i < NUM_BINS; i++) begin
						here_store[b][i] = 0;
						shift_store[b][i] = 0;
					end
			end
			CMD_DEPOSIT: begin
				if (r.active && int'(r.beam) < NUM_BEAMS) begin
					inv = longint'(inv_dt_now);
					off = longint'($signed(r.offset));
					mag = (off < 0) ? -off : off;
					// neighbour fraction in Q16, clamped at one so the own weight never goes negative
					frac = mag * inv;
					if (frac > 65536)
						frac = 65536;
					own_w = 65536 - frac;
					chg = longint'($signed(r.charge));
					share = (chg * (own_w * inv)) >>> 32;
					nshare = (chg * (frac * inv)) >>> 32;
					clip = accumulate(1'b0, int'(r.beam), int'(r.bin), share);
					clip |= accumulate(1'b0, int'(r.beam), int'(r.neighbor_bin), nshare);
					clip |= accumulate(1'b1, int'(r.beam), int'(r.bin) + 1, share);
					clip |= accumulate(1'b1, int'(r.beam), int'(r.neighbor_bin) + 1, nshare);
					res.saturated = clip;
				end
			end
			CMD_READ: begin
				if (int'(r.beam) < NUM_BEAMS && int'(r.bin) < NUM_BINS) begin
					res.sum_here = here_store[r.beam][r.bin][SUM_W-1:0];
					res.sum_shifted = shift_store[r.beam][r.bin][SUM_W-1:0];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// response checker
	always @(posedge clk) begin : check_rsp
		lcd_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_count++;
			if (pending_rsps.size() == 0) begin
				report_mismatch("response with nothing pending", rsp.sum_here, '0);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.sum_here !== want.sum_here)
					report_mismatch("sum_here", rsp.sum_here, want.sum_here);
				if (rsp.sum_shifted !== want.sum_shifted)
					report_mismatch("sum_shifted", rsp.sum_shifted, want.sum_shifted);
				if (rsp.saturated !== want.saturated)
					report_mismatch("saturated", {{(SUM_W-1){1'b0}}, rsp.saturated},
						{{(SUM_W-1){1'b0}}, want.saturated});
			end
		end
	end

	// one request through the handshake, prediction taken at acceptance
	task automatic send_req(input lcd_req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsps.push_back(predict_deposition(r));
		case (r.cmd)
			CMD_CLEAR:   n_clears++;
			CMD_DEPOSIT: n_deposits++;
			CMD_READ:    n_reads++;
			default:     n_spare++;
		endcase
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
	endtask

	function automatic lcd_req_t make_req(input logic [1:0] cmd, input bit beam_no,
			input int bin_no, input int nbr, input int off, input int chg, input bit act);
		lcd_req_t r;
		r.cmd = cmd;
		r.beam = beam_no;
		r.bin = bin_no[9:0];
		r.neighbor_bin = nbr[9:0];
		r.offset = off[15:0];
		r.charge = chg[23:0];
		r.active = act;
		return r;
	endfunction

	// bins cluster in small windows at both ends so reads find deposits
	function automatic int pick_bin();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(7);
			4, 5:       return $urandom_range(1023, 1016);
			6:          return 1023;
			default:    return $urandom_range(1023);
		endcase
	endfunction

	function automatic lcd_req_t random_req();
		lcd_req_t r;
		int       sel, b, nbr, off, chg;
		r = make_req(CMD_SPARE, 1'($urandom), $urandom, $urandom, $urandom, $urandom,
			1'($urandom));
		sel = $urandom_range(999);
		b = pick_bin();
		if (sel < 5) begin
			r.cmd = CMD_CLEAR;
		end else if (sel < 560) begin
			// well-formed particle: neighbour mostly next to its bin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7: nbr = b + 1;
				8, 9, 10, 11:           nbr = b - 1;
				12, 13, 14:             nbr = b;
				default:                nbr = $urandom;
			endcase
			case ($urandom_range(9))
				0: begin
					case ($urandom_range(4))
						0:       off = -32768;
						1:       off = 32767;
						2:       off = 0;
						3:       off = -1;
						default: off = 1;
					endcase
				end
				1, 2, 3, 4: off = int'($urandom_range(600)) - 300;
				default:    off = $urandom;
			endcase
			case ($urandom_range(7))
				0: begin
					case ($urandom_range(3))
						0:       chg = 8388607;
						1:       chg = -8388608;
						2:       chg = 0;
						default: chg = -1;
					endcase
				end
				default: chg = $urandom;
			endcase
			r = make_req(CMD_DEPOSIT, 1'($urandom), b, nbr, off, chg,
				($urandom_range(9) != 0));
		end else if (sel < 940) begin
			r.cmd = CMD_READ;
			r.bin = b[9:0];
		end
		return r;
	endfunction

	task automatic run_traffic(input int count, input int idle_pct, input int stall_pct,
			input logic [15:0] inv);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= inv;
		@(posedge clk);
		cfg_we <= 1'b0;
		inv_dt_now = inv;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (count)
			send_req(random_req());
	endtask

	// extremes of the fields and the special cases, at the reset bin width
	task automatic test_directed_cases();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_req(make_req(CMD_READ,    0, 0,    0,    0,      0,        1));
		send_req(make_req(CMD_DEPOSIT, 0, 5,    6,    0,      8388607,  1));
		// huge offset: neighbour fraction clamped to one
		send_req(make_req(CMD_DEPOSIT, 0, 5,    4,    -32768, -8388608, 1));
		send_req(make_req(CMD_DEPOSIT, 0, 5,    6,    32767,  1000,     1));
		// small negative charge rounds towards minus infinity
		send_req(make_req(CMD_DEPOSIT, 0, 6,    5,    100,    -1,       1));
		// top bin: shifted write past the end is dropped
		send_req(make_req(CMD_DEPOSIT, 1, 1023, 1022, 64,     8388607,  1));
		send_req(make_req(CMD_DEPOSIT, 1, 1022, 1023, -64,    -8388608, 1));
		// own and neighbour bin the same entry
		send_req(make_req(CMD_DEPOSIT, 1, 7,    7,    128,    12345,    1));
		send_req(make_req(CMD_DEPOSIT, 0, 5,    6,    10,     8388607,  0));
		send_req(make_req(CMD_SPARE,   1, 1023, 1023, -1,     -1,       1));
		send_req(make_req(CMD_READ,    0, 4,    0,    0,      0,        0));
		send_req(make_req(CMD_READ,    0, 5,    0,    0,      0,        0));
		send_req(make_req(CMD_READ,    0, 6,    0,    0,      0,        0));
		send_req(make_req(CMD_READ,    0, 7,    0,    0,      0,        0));
		send_req(make_req(CMD_READ,    1, 7,    0,    0,      0,        0));
		send_req(make_req(CMD_READ,    1, 8,    0,    0,      0,        0));
		send_req(make_req(CMD_READ,    1, 1022, 0,    0,      0,        0));
		send_req(make_req(CMD_READ,    1, 1023, 1023, -1,     -1,       1));
		send_req(make_req(CMD_READ,    1, 0,    0,    0,      0,        0));
		// clear ignores the beam field and wipes every beam
		send_req(make_req(CMD_CLEAR,   1, 1023, 1023, -1,     -1,       1));
		send_req(make_req(CMD_READ,    0, 5,    0,    0,      0,        0));
		send_req(make_req(CMD_READ,    1, 1023, 0,    0,      0,        0));
	endtask

	task automatic test_back_to_back();
		run_traffic(330, 0, 0, 16'hFFFF);
	endtask

	task automatic test_sender_gaps();
		run_traffic(330, 60, 0, 16'h0000);
	endtask

	task automatic test_receiver_stalls();
		run_traffic(330, 0, 60, 16'd1);
	endtask

	task automatic test_mixed_idling();
		run_traffic(330, 16, 16, 16'($urandom_range(400, 2)));
	endtask

	task automatic test_default_width();
		run_traffic(310, 16, 60, INV_DT_RESET);
	endtask

	initial begin
		inv_dt_now = INV_DT_RESET;
		foreach (here_store[b, i]) begin
			here_store[b][i] = 0;
			shift_store[b][i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();
		test_default_width();
		wait_idle();
		repeat (16) @(posedge clk);
		$display("%0d deposits, %0d reads, %0d clears and %0d unused commands sent",
			n_deposits, n_reads, n_clears, n_spare);
		$display("%0d responses checked over six traffic phases, %0d mismatches",
			rsp_count, mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
